// ===== rtl/iiee_pkg.sv =====
// Package for the infix expression evaluator: codes, command and status structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package iiee_pkg;

	localparam int OperatorDepth = 16;
	localparam int ValueDepth = 16;
	localparam int ValueWidth = 32;
	localparam int ResultWidth = 32;

	localparam logic [7:0] ChPlus = 8'd43;
	localparam logic [7:0] ChMinus = 8'd45;
	localparam logic [7:0] ChStar = 8'd42;
	localparam logic [7:0] ChSlash = 8'd47;
	localparam logic [7:0] ChLpar = 8'd40;
	localparam logic [7:0] ChRpar = 8'd41;
	localparam logic [7:0] ChEquals = 8'd61;
	localparam logic [7:0] ChZero = 8'd48;
	localparam logic [7:0] ChNine = 8'd57;
	localparam int Radix = 10;

	typedef enum logic [2:0] {
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_LPAREN = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DIVZERO = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_MALFORMED = 2'd3
	} st_t;

	typedef enum logic [3:0] {
		CH_DIGIT,
		CH_PLUS,
		CH_MINUS,
		CH_STAR,
		CH_SLASH,
		CH_LPAR,
		CH_RPAR,
		CH_EQ,
		CH_OTHER
	} cls_t;

	typedef enum logic [1:0] {
		VS_TOP,
		VS_NEXT,
		VS_BOTTOM
	} vsel_t;

	typedef struct packed {
		logic load_char;
		logic acc_digit;
		logic end_num;
		logic op_read;
		logic op_pop;
		logic op_push;
		op_t op_code;
		logic v_read;
		vsel_t v_sel;
		logic latch_rhs;
		logic v_pop2;
		logic alu_start;
		logic push_res;
		logic fail;
		st_t fail_code;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic err;
		logic opcnt_zero;
		logic vcnt_lt2;
		logic vcnt_one;
		op_t op_top;
		logic alu_done;
		logic alu_divzero;
		logic out_free;
	} stat_t;

	function automatic cls_t classify(input logic [7:0] ch);
		cls_t c;
		c = CH_OTHER;
		if (ch >= ChZero && ch <= ChNine) c = CH_DIGIT;
		else if (ch == ChPlus) c = CH_PLUS;
		else if (ch == ChMinus) c = CH_MINUS;
		else if (ch == ChStar) c = CH_STAR;
		else if (ch == ChSlash) c = CH_SLASH;
		else if (ch == ChLpar) c = CH_LPAR;
		else if (ch == ChRpar) c = CH_RPAR;
		else if (ch == ChEquals) c = CH_EQ;
		return c;
	endfunction

endpackage

// ===== rtl/iiee_if.sv =====
// Channel interfaces of the evaluator: character input and result output.
// Depends on iiee_pkg for the result width.
`timescale 1ns / 1ps

interface iiee_char_if;
	logic valid;
	logic ready;
	logic [7:0] character;
	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface iiee_result_if;
	logic valid;
	logic ready;
	logic signed [iiee_pkg::ResultWidth-1:0] value;
	logic [1:0] status;
	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ===== rtl/iiee_alu.sv =====
// Iterative arithmetic unit: registered add/subtract, shift-add multiply and
// restoring divide one bit per cycle. Depends on iiee_pkg.
`timescale 1ns / 1ps

module iiee_alu #(
	parameter int VW = iiee_pkg::ValueWidth
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input iiee_pkg::op_t op,
	input logic [VW-1:0] lhs,
	input logic [VW-1:0] rhs,
	output logic done,
	output logic divzero,
	output logic [VW-1:0] res
);
	import iiee_pkg::*;

	localparam int CW = $clog2(VW + 1);

	logic busy_q, done_q, dz_q, is_div_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] a_q, b_q, p_q;
	logic [VW:0] r_q;
	logic [VW-1:0] lhs_mag, rhs_mag;
	logic [VW:0] trial;
	logic fits;

	assign lhs_mag = lhs[VW-1] ? (~lhs + VW'(1)) : lhs;
	assign rhs_mag = rhs[VW-1] ? (~rhs + VW'(1)) : rhs;
	assign trial = {r_q[VW-1:0], p_q[VW-1]};
	assign fits = trial >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dz_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dz_q <= 1'b0;
				cnt_q <= CW'(VW);
				unique case (op)
					OP_MUL: busy_q <= 1'b1;
					OP_DIV: begin
						if (rhs == '0) begin
							dz_q <= 1'b1;
							done_q <= 1'b1;
						end else begin
							busy_q <= 1'b1;
						end
					end
					default: done_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			is_div_q <= 1'b0;
			neg_q <= 1'b0;
			unique case (op)
				OP_ADD: p_q <= lhs + rhs;
				OP_SUB: p_q <= lhs - rhs;
				OP_MUL: begin
					a_q <= lhs;
					b_q <= rhs;
					p_q <= '0;
				end
				OP_DIV: begin
					is_div_q <= 1'b1;
					neg_q <= lhs[VW-1] ^ rhs[VW-1];
					p_q <= lhs_mag;
					b_q <= rhs_mag;
					r_q <= '0;
				end
				default: p_q <= '0;
			endcase
		end else if (busy_q) begin
			if (is_div_q) begin
				r_q <= fits ? (trial - {1'b0, b_q}) : trial;
				p_q <= {p_q[VW-2:0], fits};
			end else begin
				if (b_q[0]) p_q <= p_q + a_q;
				a_q <= {a_q[VW-2:0], 1'b0};
				b_q <= {1'b0, b_q[VW-1:1]};
			end
		end
	end

	assign done = done_q;
	assign divzero = dz_q;
	assign res = neg_q ? (~p_q + VW'(1)) : p_q;

endmodule

// ===== rtl/iiee_dp.sv =====
// Datapath: operator and value stacks, number accumulator, error code, output
// register. Depends on iiee_pkg, iiee_result_if and iiee_alu.
`timescale 1ns / 1ps

module iiee_dp #(
	parameter int OD = iiee_pkg::OperatorDepth,
	parameter int VD = iiee_pkg::ValueDepth,
	parameter int VW = iiee_pkg::ValueWidth
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] character,
	input iiee_pkg::cmd_t cmd,
	output iiee_pkg::stat_t stat,
	iiee_result_if.source result
);
	import iiee_pkg::*;

	localparam int OCW = $clog2(OD + 1);
	localparam int VCW = $clog2(VD + 1);
	localparam int OAW = $clog2(OD);
	localparam int VAW = $clog2(VD);

	op_t op_mem [OD];
	logic [VW-1:0] v_mem [VD];

	logic [7:0] char_q;
	logic [OCW-1:0] opcnt_q, op_dec;
	logic [VCW-1:0] vcnt_q, v_dec1, v_dec2, v_raddr;
	logic [VW-1:0] acc_q, v_rd_q, rhs_q, v_wdata, alu_res;
	logic nip_q;
	st_t err_q, err_set;
	op_t op_rd_q;
	logic out_valid_q;
	logic [ResultWidth-1:0] out_value_q;
	st_t out_status_q;
	logic op_full, v_full, vpush, op_ok, v_ok, alu_done, alu_dz;
	logic [63:0] ext;

	assign op_dec = opcnt_q - OCW'(1);
	assign v_dec1 = vcnt_q - VCW'(1);
	assign v_dec2 = vcnt_q - VCW'(2);
	assign op_full = opcnt_q == OCW'(OD);
	assign v_full = vcnt_q == VCW'(VD);
	assign vpush = (cmd.end_num && nip_q) || cmd.push_res;
	assign op_ok = cmd.op_push && !op_full;
	assign v_ok = vpush && !v_full;
	assign v_wdata = cmd.push_res ? alu_res : acc_q;
	assign ext = 64'(signed'(v_rd_q));

	always_comb begin
		unique case (cmd.v_sel)
			VS_TOP: v_raddr = v_dec1;
			VS_NEXT: v_raddr = v_dec2;
			default: v_raddr = '0;
		endcase
	end

	always_comb begin
		err_set = ST_OK;
		if (cmd.fail) err_set = cmd.fail_code;
		else if ((vpush && v_full) || (cmd.op_push && op_full)) err_set = ST_OVERFLOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcnt_q <= '0;
			vcnt_q <= '0;
			acc_q <= '0;
			nip_q <= 1'b0;
			err_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) out_valid_q <= 1'b0;
			if (cmd.load_out) out_valid_q <= 1'b1;
			if (cmd.clear) begin
				opcnt_q <= '0;
				vcnt_q <= '0;
				acc_q <= '0;
				nip_q <= 1'b0;
				err_q <= ST_OK;
			end else begin
				if (err_q == ST_OK) err_q <= err_set;
				if (cmd.acc_digit) begin
					acc_q <= (acc_q << 3) + (acc_q << 1) + VW'(char_q[3:0]);
					nip_q <= 1'b1;
				end else if (cmd.end_num) begin
					acc_q <= '0;
					nip_q <= 1'b0;
				end
				if (op_ok) opcnt_q <= opcnt_q + OCW'(1);
				else if (cmd.op_pop) opcnt_q <= op_dec;
				if (v_ok) vcnt_q <= vcnt_q + VCW'(1);
				else if (cmd.v_pop2) vcnt_q <= v_dec2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_char) char_q <= character;
		if (op_ok) op_mem[opcnt_q[OAW-1:0]] <= cmd.op_code;
		if (cmd.op_read) op_rd_q <= op_mem[op_dec[OAW-1:0]];
		if (v_ok) v_mem[vcnt_q[VAW-1:0]] <= v_wdata;
		if (cmd.v_read) v_rd_q <= v_mem[v_raddr[VAW-1:0]];
		if (cmd.latch_rhs) rhs_q <= v_rd_q;
		if (cmd.load_out) begin
			out_value_q <= (err_q == ST_OK) ? ext[ResultWidth-1:0] : '0;
			out_status_q <= err_q;
		end
	end

	iiee_alu #(.VW(VW)) u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.alu_start),
		.op(op_rd_q),
		.lhs(v_rd_q),
		.rhs(rhs_q),
		.done(alu_done),
		.divzero(alu_dz),
		.res(alu_res)
	);

	assign stat.cls = classify(char_q);
	assign stat.err = err_q != ST_OK;
	assign stat.opcnt_zero = opcnt_q == '0;
	assign stat.vcnt_lt2 = vcnt_q < VCW'(2);
	assign stat.vcnt_one = vcnt_q == VCW'(1);
	assign stat.op_top = op_rd_q;
	assign stat.alu_done = alu_done;
	assign stat.alu_divzero = alu_dz;
	assign stat.out_free = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.value = out_value_q;
	assign result.status = out_status_q;

endmodule

// ===== rtl/iiee_ctrl.sv =====
// Controller: sequences decode, operator reduction loops and result output.
// Depends on iiee_pkg; drives the datapath by command struct.
`timescale 1ns / 1ps

module iiee_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input iiee_pkg::stat_t stat,
	output iiee_pkg::cmd_t cmd
);
	import iiee_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DISPATCH,
		S_LOOP,
		S_OPCHK,
		S_RDL,
		S_LAT,
		S_ALU,
		S_LOOPEND,
		S_OUT
	} state_t;

	state_t state_q, state_d;
	logic stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		unique case (stat.cls)
			CH_PLUS, CH_MINUS, CH_RPAR: stop = stat.op_top == OP_LPAREN;
			CH_STAR, CH_SLASH: stop = !(stat.op_top == OP_MUL || stat.op_top == OP_DIV);
			default: stop = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op_code = OP_LPAREN;
		cmd.v_sel = VS_TOP;
		cmd.fail_code = ST_MALFORMED;
		in_ready = 1'b0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_char = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.cls == CH_EQ) begin
					cmd.end_num = !stat.err;
					state_d = S_LOOP;
				end else if (stat.err) begin
					state_d = S_IDLE;
				end else if (stat.cls == CH_DIGIT) begin
					cmd.acc_digit = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.end_num = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				if (!stat.err) begin
					priority case (stat.cls)
						CH_LPAR: cmd.op_push = 1'b1;
						CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_RPAR: state_d = S_LOOP;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LOOP: begin
				if (stat.err || stat.opcnt_zero) begin
					state_d = S_LOOPEND;
				end else begin
					cmd.op_read = 1'b1;
					state_d = S_OPCHK;
				end
			end
			S_OPCHK: begin
				if (stat.cls == CH_EQ && stat.op_top == OP_LPAREN) begin
					cmd.fail = 1'b1;
					state_d = S_LOOP;
				end else if (stop) begin
					state_d = S_LOOPEND;
				end else begin
					cmd.op_pop = 1'b1;
					if (stat.vcnt_lt2) begin
						cmd.fail = 1'b1;
						state_d = S_LOOP;
					end else begin
						cmd.v_read = 1'b1;
						state_d = S_RDL;
					end
				end
			end
			S_RDL: begin
				cmd.latch_rhs = 1'b1;
				cmd.v_read = 1'b1;
				cmd.v_sel = VS_NEXT;
				state_d = S_LAT;
			end
			S_LAT: begin
				cmd.v_pop2 = 1'b1;
				cmd.alu_start = 1'b1;
				state_d = S_ALU;
			end
			S_ALU: begin
				if (stat.alu_done) begin
					if (stat.alu_divzero) begin
						cmd.fail = 1'b1;
						cmd.fail_code = ST_DIVZERO;
					end else begin
						cmd.push_res = 1'b1;
					end
					state_d = S_LOOP;
				end
			end
			S_LOOPEND: begin
				state_d = S_IDLE;
				priority case (stat.cls)
					CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
						cmd.op_push = !stat.err;
						priority case (stat.cls)
							CH_PLUS: cmd.op_code = OP_ADD;
							CH_MINUS: cmd.op_code = OP_SUB;
							CH_STAR: cmd.op_code = OP_MUL;
							default: cmd.op_code = OP_DIV;
						endcase
					end
					CH_RPAR: begin
						if (!stat.err) begin
							if (stat.opcnt_zero) cmd.fail = 1'b1;
							else cmd.op_pop = 1'b1;
						end
					end
					CH_EQ: begin
						cmd.fail = !stat.err && !stat.vcnt_one;
						cmd.v_read = 1'b1;
						cmd.v_sel = VS_BOTTOM;
						state_d = S_OUT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/infix_integer_expression_evaluator.sv =====
// channel  | dir | payload                         | handshake
// expr     | in  | character[7:0]                  | valid/ready
// result   | out | value[31:0] signed, status[1:0] | valid/ready
//
// A digit goes through decode only; '(' and ignored characters also go through dispatch
// unless an error is held. + - * / and ')' then run the reduction loop, with an operator
// check that stops it at an operator or '('; a reduced * or / iterates VW bits in the ALU.
// '=' runs the loop too, and takes an extra check and loop pass when it meets an open '('.
// Result register frees the input side; '=' holds in its output state while a result waits.
// Reset clears counts, accumulator and error; stacks hold no reset value.
// Top level of the two-stack infix evaluator. Depends on iiee_pkg, the channel
// interfaces, iiee_ctrl and iiee_dp.
`timescale 1ns / 1ps

module infix_integer_expression_evaluator #(
	parameter int OPERATOR_DEPTH = iiee_pkg::OperatorDepth,
	parameter int VALUE_DEPTH = iiee_pkg::ValueDepth,
	parameter int VALUE_WIDTH = iiee_pkg::ValueWidth
) (
	input logic clk,
	input logic arst_n,
	iiee_char_if.sink expr,
	iiee_result_if.source result
);
	import iiee_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic rdy;

	assign expr.ready = rdy;

	iiee_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(expr.valid),
		.in_ready(rdy),
		.stat(stat),
		.cmd(cmd)
	);

	iiee_dp #(
		.OD(OPERATOR_DEPTH),
		.VD(VALUE_DEPTH),
		.VW(VALUE_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.character(expr.character),
		.cmd(cmd),
		.stat(stat),
		.result(result)
	);

endmodule

// ===== rtl/iiee_checker.sv =====
// Port-level checks of the evaluator, bound to the top level.
// Depends on iiee_pkg for status codes.
`timescale 1ns / 1ps

module iiee_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_value,
	input logic [1:0] out_status
);
	import iiee_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
		else $error("result payload changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_value == '0)
		else $error("error result carries a nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input side was idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in back-to-back cycles");

endmodule

bind infix_integer_expression_evaluator iiee_checker u_iiee_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(expr.valid),
	.in_ready(expr.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_value(result.value),
	.out_status(result.status)
);

// ===== tb/infix_integer_expression_evaluator_tb.sv =====
// Testbench for the infix integer expression evaluator: directed and random expressions.
// Predicts each result with a two-stack evaluator of its own and checks it field by field.
// Depends on iiee_pkg, the channel interfaces and the evaluator top level.
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_tb;
	import iiee_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		st_t status;
	} answer_t;

	logic clk;
	logic arst_n;
	iiee_char_if expr ();
	iiee_result_if result ();

	infix_integer_expression_evaluator dut (
		.clk(clk),
		.arst_n(arst_n),
		.expr(expr.sink),
		.result(result.source)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	logic [7:0] char_q[$];
	answer_t answer_q[$];
	int errors = 0;
	int chars_taken = 0;
	int idle_cycles = 0;
	bit took = 0;
	bit no_gaps = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cycles = 0;
	bit held = 0;

	// evaluator state
	logic [31:0] val_stack[ValueDepth];
	op_t op_stack[OperatorDepth];
	int op_cnt;
	int val_cnt;
	logic [31:0] acc;
	bit in_number;
	st_t err;

	function automatic void flag(st_t c);
		if (err == ST_OK) err = c;
	endfunction

	function automatic void push_val(logic [31:0] v);
		if (val_cnt >= ValueDepth) flag(ST_OVERFLOW);
		else begin
			val_stack[val_cnt] = v;
			val_cnt++;
		end
	endfunction

	function automatic void push_op(op_t o);
		if (op_cnt >= OperatorDepth) flag(ST_OVERFLOW);
		else begin
			op_stack[op_cnt] = o;
			op_cnt++;
		end
	endfunction

	function automatic void end_number();
		if (in_number) begin
			in_number = 0;
			push_val(acc);
			acc = '0;
		end
	endfunction

	function automatic void apply_top();
		op_t o;
		logic [31:0] lhs, rhs, ml, mr, res;
		if (op_cnt == 0) return;
		o = op_stack[op_cnt-1];
		op_cnt--;
		if (val_cnt < 2) begin
			flag(ST_MALFORMED);
			return;
		end
		rhs = val_stack[val_cnt-1];
		lhs = val_stack[val_cnt-2];
		val_cnt -= 2;
		case (o)
			OP_ADD: res = lhs + rhs;
			OP_SUB: res = lhs - rhs;
			OP_MUL: res = lhs * rhs;
			OP_DIV: begin
				if (rhs == 0) begin
					flag(ST_DIVZERO);
					return;
				end
				ml = lhs[31] ? -lhs : lhs;
				mr = rhs[31] ? -rhs : rhs;
				res = ml / mr;
				if (lhs[31] != rhs[31]) res = -res;
			end
			default: begin
				flag(ST_MALFORMED);
				return;
			end
		endcase
		push_val(res);
	endfunction

	function automatic void clear_state();
		op_cnt = 0;
		val_cnt = 0;
		acc = '0;
		in_number = 0;
		err = ST_OK;
	endfunction

	function automatic void evaluate_char(logic [7:0] ch);
		answer_t a;
		if (ch == ChEquals) begin
			if (err == ST_OK) end_number();
			while (err == ST_OK && op_cnt > 0) begin
				if (op_stack[op_cnt-1] == OP_LPAREN) flag(ST_MALFORMED);
				else apply_top();
			end
			if (err == ST_OK && val_cnt != 1) flag(ST_MALFORMED);
			a.value = (err == ST_OK) ? val_stack[0] : '0;
			a.status = err;
			answer_q.push_back(a);
			clear_state();
			return;
		end
		if (err != ST_OK) return;
		if (ch >= ChZero && ch <= ChNine) begin
			acc = acc * 32'd10 + 32'(ch - ChZero);
			in_number = 1;
			return;
		end
		end_number();
		if (err != ST_OK) return;
		case (ch)
			ChPlus, ChMinus: begin
				while (err == ST_OK && op_cnt > 0 && op_stack[op_cnt-1] != OP_LPAREN)
					apply_top();
				if (err == ST_OK) push_op(ch == ChPlus ? OP_ADD : OP_SUB);
			end
			ChStar, ChSlash: begin
				while (err == ST_OK && op_cnt > 0 &&
					(op_stack[op_cnt-1] == OP_MUL || op_stack[op_cnt-1] == OP_DIV))
					apply_top();
				if (err == ST_OK) push_op(ch == ChStar ? OP_MUL : OP_DIV);
			end
			ChLpar: push_op(OP_LPAREN);
			ChRpar: begin
				while (err == ST_OK && op_cnt > 0 && op_stack[op_cnt-1] != OP_LPAREN)
					apply_top();
				if (err == ST_OK) begin
					if (op_cnt == 0) flag(ST_MALFORMED);
					else op_cnt--;
				end
			end
			default: ;
		endcase
	endfunction

	// stimulus builders
	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
	endfunction

	function automatic void add_number();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
		if ($urandom_range(0, 9) == 0) begin
			char_q.push_back(ChZero);
			return;
		end
		for (int i = 0; i < n; i++) char_q.push_back(8'($urandom_range(ChZero, ChNine)));
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0: return ChPlus;
			1: return ChMinus;
			2: return ChStar;
			default: return ChSlash;
		endcase
	endfunction

	function automatic void add_expr(int depth);
		int terms;
		terms = $urandom_range(1, 4);
		for (int t = 0; t < terms; t++) begin
			if (t > 0) char_q.push_back(pick_op());
			if ($urandom_range(0, 19) == 0) char_q.push_back(8'd32);
			if (depth > 0 && $urandom_range(0, 3) == 0) begin
				char_q.push_back(ChLpar);
				add_expr(depth - 1);
				char_q.push_back(ChRpar);
			end else add_number();
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (expr.valid && expr.ready) begin
			evaluate_char(expr.character);
			chars_taken++;
			took = 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!expr.valid || took)) begin
			took = 0;
			if (send_gap > 0) begin
				send_gap--;
				expr.valid <= 1'b0;
			end else if (char_q.size() > 0) begin
				expr.character <= char_q.pop_front();
				expr.valid <= 1'b1;
				if (no_gaps || $urandom_range(0, 9) < 6) send_gap = 0;
				else if ($urandom_range(0, 29) == 0) send_gap = $urandom_range(20, 60);
				else send_gap = $urandom_range(1, 3);
			end else expr.valid <= 1'b0;
		end
	end

	// result side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held && chars_taken >= 400) begin
				held = 1;
				hold_cycles = 600;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				result.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 9) < 3)
					recv_gap = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 3);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t a;
		if (result.valid && result.ready) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected result value=%0d status=%0d", $time,
					result.value, result.status);
				errors++;
			end else begin
				a = answer_q.pop_front();
				if (result.value !== a.value || result.status !== a.status) begin
					$display("%0t: mismatch expected value=%0d status=%0d, got value=%0d status=%0d",
						$time, a.value, a.status, result.value, result.status);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((expr.valid && expr.ready) || (result.valid && result.ready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		expr.valid = 1'b0;
		expr.character = 8'd0;
		result.ready = 1'b0;
		clear_state();
		arst_n = 1'b0;
		add_text("0=2147483647=4294967295=7+3=9-12=6*7=100/7=");
		add_text("2*3+4=2+3*4=8-3-2=64/4/2=(1+2)*3=-7/2=(0-7)/2=");
		add_text("5/0=1/0+5=99999999999=(0-2147483647-1)/(0-1)=");
		add_text("1)=(1=1 2==+=((((((((((((((((((1=");
		add_text("1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8=");
		add_text("1+(2+(3+(4+(5+(6+(7+(8+(9+(1+(2+(3+(4+(5+(6+(7+(8+9)))))))))))))))))=");
		add_text("(((3)))a*b(2)=");
		while (char_q.size() < 1350) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 8)) char_q.push_back(8'($urandom_range(0, 255)));
			end else add_expr($urandom_range(0, 4));
			char_q.push_back(ChEquals);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (chars_taken > 700);
		no_gaps = 1;
		wait (chars_taken > 900);
		no_gaps = 0;
		while (char_q.size() > 0 || expr.valid) @(posedge clk);
		while (answer_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/iiee_pkg.sv
rtl/iiee_if.sv
rtl/iiee_alu.sv
rtl/iiee_dp.sv
rtl/iiee_ctrl.sv
rtl/infix_integer_expression_evaluator.sv
rtl/iiee_checker.sv
tb/infix_integer_expression_evaluator_tb.sv
